>>> sv/rsmm_pkg.sv
package rsmm_pkg;

  // Field widths of one item
  localparam int unsigned MERGE_ID_W = 16;
  localparam int unsigned SCAN_W     = 4;
  localparam int unsigned AZ_IN_W    = 12;
  localparam int unsigned LEN_W      = 11;
  localparam int unsigned CELL_IN_W  = 10;
  localparam int unsigned AMP_IN_W   = 8;

  // Default configuration
  localparam int unsigned DEF_AZIMUTH_STEPS = 4096;
  localparam int unsigned DEF_MAX_CELLS     = 1024;
  localparam int unsigned DEF_AMP_BITS      = 8;

  // Command codes carried in tuser
  localparam logic CMD_MERGE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_COPY = 2'd0,
    STAT_MAX  = 2'd1,
    STAT_DROP = 2'd2,
    STAT_READ = 2'd3
  } status_t;

  // One azimuth line descriptor
  typedef struct packed {
    logic                  valid;
    logic [MERGE_ID_W-1:0] tag;
    logic [SCAN_W-1:0]     creator;
    logic [LEN_W-1:0]      count;
  } line_entry_t;

endpackage

>>> sv/rsmm_line_table.sv
module rsmm_line_table #(
  parameter int unsigned AZIMUTH_STEPS = rsmm_pkg::DEF_AZIMUTH_STEPS,
  localparam int unsigned AZ_W = $clog2(AZIMUTH_STEPS)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  rd_en,
  input  logic [AZ_W-1:0]       rd_addr,
  output rsmm_pkg::line_entry_t rd_data,
  input  logic                  wr_en,
  input  logic [AZ_W-1:0]       wr_addr,
  input  rsmm_pkg::line_entry_t wr_data,
  output logic                  busy
);

  rsmm_pkg::line_entry_t mem [AZIMUTH_STEPS];
  logic [AZ_W-1:0]       clr_addr;

  // Sweep the table once after reset, clearing every valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      if (clr_addr == AZ_W'(AZIMUTH_STEPS - 1)) begin
        busy <= 1'b0;
      end else begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  // Write port: the clearing sweep owns it while busy
  always_ff @(posedge clk) begin
    if (busy && !rst) begin
      mem[clr_addr] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> sv/rsmm_cell_ram.sv
module rsmm_cell_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 8,
  localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single write port, registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> sv/radar_scan_max_hold_merge.sv
// Radar scan peak-hold merge.
// Input channel s_*: one transfer is either an echo sample to merge
// (s_tuser = merge) or a read of one merged cell (s_tuser = read).
// A sample whose azimuth line is absent from the current merge generation
// creates the line; later samples of the creating scan overwrite cells,
// samples of other scans keep the per-cell peak when line lengths match,
// and are dropped otherwise.
// Output channel m_*: exactly one result transfer per input transfer,
// carrying the status code, the cell amplitude and the line-present flag.
// Timing: an accepted item moves to ST_READ, where its line descriptor and cell
// are read from the two memories, then to ST_EXEC, where the result is
// registered and m_tvalid rises once the output register is free.
// One item is in flight at a time: a new item is not accepted until the last
// one has left ST_EXEC, as it does a read-modify-write through the memories.
// Reset: the line table is swept to clear its valid bits, one entry per
// cycle, and s_tready stays low until the sweep is done.
// Stall: a result waits in the output register while m_tready is low; the
// next item may be accepted meanwhile, and its result waits until the
// register is free.
module radar_scan_max_hold_merge #(
  parameter int unsigned AZIMUTH_STEPS = rsmm_pkg::DEF_AZIMUTH_STEPS,
  parameter int unsigned MAX_CELLS     = rsmm_pkg::DEF_MAX_CELLS,
  parameter int unsigned AMP_BITS      = rsmm_pkg::DEF_AMP_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // merge_id[15:0], scan_index[19:16], azimuth[31:20], line_length[42:32],
  // cell_req[52:43], amplitude[60:53], zero fill [63:61]
  input  logic [63:0] s_tdata,
  // command[0]
  input  logic [0:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // merged_amplitude[7:0], line_present[8], zero fill [15:9]
  output logic [15:0] m_tdata,
  // status[1:0]
  output logic [1:0]  m_tuser
);

  localparam int unsigned AZ_W     = $clog2(AZIMUTH_STEPS);
  localparam int unsigned CELLS_T  = AZIMUTH_STEPS * MAX_CELLS;
  localparam int unsigned CADDR_W  = $clog2(CELLS_T);

  typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_EXEC} state_t;

  state_t state;

  // Held input item
  logic                            cmd_r;
  logic [rsmm_pkg::MERGE_ID_W-1:0] mid_r;
  logic [rsmm_pkg::SCAN_W-1:0]     scan_r;
  logic [rsmm_pkg::AZ_IN_W-1:0]    az_r;
  logic [rsmm_pkg::LEN_W-1:0]      len_r;
  logic [rsmm_pkg::CELL_IN_W-1:0]  cell_r;
  logic [rsmm_pkg::AMP_IN_W-1:0]   amp_r;

  logic [rsmm_pkg::AZ_IN_W-1:0] az_mod;
  logic [AZ_W-1:0]              az_idx;
  logic [CADDR_W-1:0]           cell_addr;

  rsmm_pkg::line_entry_t line_rd;
  rsmm_pkg::line_entry_t line_wr;
  logic                  line_rd_en;
  logic                  line_wr_en;
  logic                  clear_busy;

  logic                cell_rd_en;
  logic                cell_wr_en;
  logic [AMP_BITS-1:0] cell_rd;
  logic [AMP_BITS-1:0] cell_wr;
  logic [AMP_BITS-1:0] amp_st;

  logic                 present;
  logic                 cell_ok;
  logic [rsmm_pkg::LEN_W-1:0] count_eff;
  logic                 out_free;
  logic                 exec_go;
  rsmm_pkg::status_t    status_next;
  logic [7:0]           amp_next;
  logic                 present_next;

  // Wrap the azimuth into the table range by conditional subtraction
  always_comb begin
    az_mod = az_r;
    for (int k = 3; k >= 0; k--) begin
      if (32'(az_mod) >= (AZIMUTH_STEPS << k)) begin
        az_mod = az_mod - rsmm_pkg::AZ_IN_W'(AZIMUTH_STEPS << k);
      end
    end
  end

  assign az_idx    = AZ_W'(az_mod);
  assign cell_addr = CADDR_W'(32'(az_idx) * MAX_CELLS + 32'(cell_r));
  assign amp_st    = AMP_BITS'(amp_r);

  // Handshake and phase control
  assign s_tready   = (state == ST_IDLE) && !clear_busy;
  assign out_free   = !m_tvalid || m_tready;
  assign exec_go    = (state == ST_EXEC) && out_free;
  assign line_rd_en = (state == ST_READ);
  assign cell_rd_en = (state == ST_READ);

  // Decide the result and the write-back from the fetched line and cell
  always_comb begin
    present      = line_rd.valid && (line_rd.tag == mid_r);
    cell_ok      = 32'(cell_r) < MAX_CELLS;
    count_eff    = present ? line_rd.count : len_r;
    line_wr      = '{valid: 1'b1, tag: mid_r, creator: scan_r, count: len_r};
    line_wr_en   = 1'b0;
    cell_wr_en   = 1'b0;
    cell_wr      = amp_st;
    amp_next     = '0;
    present_next = 1'b1;
    status_next  = rsmm_pkg::STAT_DROP;
    priority if (cmd_r == rsmm_pkg::CMD_READ) begin
      status_next  = rsmm_pkg::STAT_READ;
      present_next = present;
      if (present && (11'(cell_r) < line_rd.count) && cell_ok) begin
        amp_next = 8'(cell_rd);
      end
    end else if (!present || (line_rd.creator == scan_r)) begin
      // create the line if absent, then copy the sample
      status_next = rsmm_pkg::STAT_COPY;
      line_wr_en  = exec_go && !present;
      if ((11'(cell_r) < count_eff) && cell_ok) begin
        cell_wr_en = exec_go;
        amp_next   = 8'(amp_st);
      end
    end else if (line_rd.count == len_r) begin
      // keep the peak of stored and new amplitude
      status_next = rsmm_pkg::STAT_MAX;
      if ((11'(cell_r) < len_r) && cell_ok) begin
        cell_wr    = (cell_rd < amp_st) ? amp_st : cell_rd;
        cell_wr_en = exec_go;
        amp_next   = 8'(cell_wr);
      end
    end else begin
      status_next = rsmm_pkg::STAT_DROP;
    end
  end

  // Sequencer, held item and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      // raise on a new result, drop once the waiting one transfers
      if (exec_go) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid && s_tready) begin
            state <= ST_READ;
          end
        end
        ST_READ: begin
          state <= ST_EXEC;
        end
        ST_EXEC: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
    // payload registers
    if (s_tvalid && s_tready) begin
      cmd_r  <= s_tuser[0];
      mid_r  <= s_tdata[15:0];
      scan_r <= s_tdata[19:16];
      az_r   <= s_tdata[31:20];
      len_r  <= s_tdata[42:32];
      cell_r <= s_tdata[52:43];
      amp_r  <= s_tdata[60:53];
    end
    if (exec_go) begin
      m_tdata <= {7'b0, present_next, amp_next};
      m_tuser <= status_next;
    end
  end

  rsmm_line_table #(
    .AZIMUTH_STEPS(AZIMUTH_STEPS)
  ) u_line_table (
    .clk    (clk),
    .rst    (rst),
    .rd_en  (line_rd_en),
    .rd_addr(az_idx),
    .rd_data(line_rd),
    .wr_en  (line_wr_en),
    .wr_addr(az_idx),
    .wr_data(line_wr),
    .busy   (clear_busy)
  );

  rsmm_cell_ram #(
    .DEPTH(CELLS_T),
    .WIDTH(AMP_BITS)
  ) u_cell_ram (
    .clk    (clk),
    .rd_en  (cell_rd_en),
    .rd_addr(cell_addr),
    .rd_data(cell_rd),
    .wr_en  (cell_wr_en),
    .wr_addr(cell_addr),
    .wr_data(cell_wr)
  );

  // Only one item in flight: an accepted item blocks the next transfer
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("second item accepted while one is in flight");

  // A result waiting on a stalled receiver holds the sequencer
  a_exec_interlock: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EXEC && m_tvalid && !m_tready) |=> (state == ST_EXEC))
    else $error("result produced while output register still full");

  // Cells are written only inside the line range
  a_cell_in_range: assert property (@(posedge clk) disable iff (rst)
    cell_wr_en |-> (32'(cell_r) < MAX_CELLS) && (state == ST_EXEC))
    else $error("cell write beyond the line range");

  // A line descriptor is only created when absent from the merge
  a_line_create: assert property (@(posedge clk) disable iff (rst)
    line_wr_en |-> !present && (cmd_r == rsmm_pkg::CMD_MERGE) && !clear_busy)
    else $error("line descriptor overwritten while present");

endmodule
